// ===== rtl/adc_channel_scan_scheduler_top_macros.svh =====
// Assertion macros for the ADC scan scheduler.
// Included by the top level; needs nothing else.
`ifndef ADC_CHANNEL_SCAN_SCHEDULER_TOP_MACROS_SVH
`define ADC_CHANNEL_SCAN_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication
`define ACSS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ACSS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/acss_pkg.sv =====
// Shared constants and types of the ADC scan scheduler.
// No dependencies.
package acss_pkg;

   localparam int CHANNELS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 8;
   localparam int SAMPLE_BITS    = 12;
   localparam int CHAN_BITS      = 4;
   localparam int OPCODE_BITS    = 2;
   localparam int WORD_BITS      = 24;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_REQUEST = 2'd0,
      OP_DONE    = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

endpackage

// ===== rtl/adc_channel_scan_scheduler_top.sv =====
// Top level of the ADC channel scan scheduler.
// Uses acss_pkg, acss_rr_search and adc_channel_scan_scheduler_top_macros.svh.
//
// Usage:
//  - req_* carries one command word: a channel request (continuous or one more
//    single conversion), a conversion-done report with its sample, or a query
//    that returns and clears a channel's done flag with its stored sample.
//  - rsp_* returns exactly one word per command: the selected channel, the
//    converter run status, and for queries the flag and sample.
//  - Per-channel pending counts with continuous marks, and the samples, live
//    in two synchronous RAMs with registered read data. A command reads
//    at acceptance, then modifies and writes back in the execute state.
//  - The response word is registered when the write-back fires, at the end
//    of the RAM read-then-write-back sequence of its command.
//  - The next command is not taken until the write-back is done, so RAM
//    accesses never overlap and need no forwarding.
//  - Reset clears all control state synchronously; per-entry valid bits make
//    unwritten RAM entries read as zero, so there is no clearing sweep.
//  - The response register decouples the sides: a command may be accepted
//    while the last response waits; its write-back then waits until the
//    response register is free.
`include "adc_channel_scan_scheduler_top_macros.svh"

module adc_channel_scan_scheduler_top #(
   parameter int Channels  = acss_pkg::CHANNELS_DEF,
   parameter int CountBits = acss_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // channel[3:0], continuous[4], sample[16:5], zero [23:17]
   input  logic [acss_pkg::WORD_BITS-1:0]    req_tdata,
   // opcode[1:0]
   input  logic [acss_pkg::OPCODE_BITS-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // active_channel[3:0], converting[4], done_flag[5], stored_sample[17:6],
   // zero [23:18]
   output logic [acss_pkg::WORD_BITS-1:0]    rsp_tdata
);

   localparam int IdxW = (Channels > 1) ? $clog2(Channels) : 1;
   localparam int EntW = CountBits + 1;   // {continuous mark, pending count}
   localparam int SmpW = acss_pkg::SAMPLE_BITS;
   localparam int ChW  = acss_pkg::CHAN_BITS;
   localparam logic [CountBits-1:0] CountMax = CountBits'((1 << CountBits) - 2);
   localparam int PadW = acss_pkg::WORD_BITS - (ChW + 2 + SmpW);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // ---------------------------------------------------------------------
   // Control and payload registers
   // ---------------------------------------------------------------------
   state_type            state_ff, state_in;
   acss_pkg::opcode_type op_ff;
   logic [IdxW-1:0]      ch_idx_ff;
   logic                 in_range_ff;
   logic                 cont_ff;
   logic [SmpW-1:0]      smp_ff;
   logic                 hit_ff;
   logic [IdxW-1:0]      hit_idx_ff;

   logic [IdxW-1:0]      cur_ff, cur_in;
   logic                 run_ff, run_in;
   logic [Channels-1:0]  done_ff, done_in;
   logic [Channels-1:0]  work_ff, work_in;
   logic [Channels-1:0]  cnt_vld_ff, cnt_vld_in;
   logic [Channels-1:0]  smp_vld_ff, smp_vld_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ChW-1:0]       rsp_chan_ff;
   logic                 rsp_conv_ff;
   logic                 rsp_flag_ff;
   logic [SmpW-1:0]      rsp_smp_ff;

   // RAMs and their registered read data
   logic [EntW-1:0]      cnt_mem_ff [Channels];
   logic [SmpW-1:0]      smp_mem_ff [Channels];
   logic [EntW-1:0]      cnt_rd_ff;
   logic [SmpW-1:0]      smp_rd_ff;

   // ---------------------------------------------------------------------
   // Input decode
   // ---------------------------------------------------------------------
   logic                 req_accept;
   acss_pkg::opcode_type req_op;
   logic [ChW-1:0]       req_ch;
   logic                 req_in_range;
   logic [IdxW-1:0]      req_idx;
   logic                 srch_found;
   logic [IdxW-1:0]      srch_idx;
   logic [IdxW-1:0]      cnt_raddr;

   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign req_op       = acss_pkg::opcode_type'(req_tuser);
   assign req_ch       = req_tdata[ChW-1:0];
   assign req_in_range = (int'(req_ch) < Channels);
   assign req_idx      = req_in_range ? IdxW'(req_ch) : '0;
   // done items read the entry of the channel the search picks
   assign cnt_raddr    = (req_op == acss_pkg::OP_DONE) ? srch_idx : req_idx;

   acss_rr_search #(
      .Channels (Channels),
      .IdxW     (IdxW)
   ) u_search (
      .work  (work_ff),
      .cur   (cur_ff),
      .found (srch_found),
      .idx   (srch_idx)
   );

   // ---------------------------------------------------------------------
   // Execute: modify and write back
   // ---------------------------------------------------------------------
   logic                 exec_fire;
   logic [IdxW-1:0]      cnt_addr;
   logic [EntW-1:0]      cnt_entry;
   logic                 ent_cont;
   logic [CountBits-1:0] ent_cnt;
   logic [CountBits-1:0] dec_cnt;
   logic                 cnt_we;
   logic [EntW-1:0]      cnt_wdata;
   logic                 smp_we;
   logic                 flag_out;
   logic [SmpW-1:0]      smp_out;

   // write-back waits while an unread response occupies the output register
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign cnt_addr  = (op_ff == acss_pkg::OP_DONE) ? hit_idx_ff : ch_idx_ff;
   assign cnt_entry = cnt_vld_ff[cnt_addr] ? cnt_rd_ff : '0;
   assign ent_cont  = cnt_entry[CountBits];
   assign ent_cnt   = cnt_entry[CountBits-1:0];
   assign dec_cnt   = ent_cnt - CountBits'(1);

   always_comb begin
      cur_in     = cur_ff;
      run_in     = run_ff;
      done_in    = done_ff;
      work_in    = work_ff;
      cnt_vld_in = cnt_vld_ff;
      smp_vld_in = smp_vld_ff;
      cnt_we     = 1'b0;
      cnt_wdata  = cnt_entry;
      smp_we     = 1'b0;
      flag_out   = 1'b0;
      smp_out    = '0;
      case (op_ff)
         acss_pkg::OP_REQUEST: begin
            if (in_range_ff) begin
               cnt_we = 1'b1;
               if (cont_ff) begin
                  cnt_wdata = {1'b1, {CountBits{1'b0}}};
               end else if (ent_cont) begin
                  cnt_wdata = {1'b0, CountBits'(1)};
               end else if (ent_cnt < CountMax) begin
                  cnt_wdata = {1'b0, ent_cnt + CountBits'(1)};
               end
               cnt_vld_in[ch_idx_ff] = 1'b1;
               work_in[ch_idx_ff]    = 1'b1;
               cur_in                = ch_idx_ff;
               run_in                = 1'b1;
            end
         end
         acss_pkg::OP_DONE: begin
            smp_we             = 1'b1;
            smp_vld_in[cur_ff] = 1'b1;
            done_in[cur_ff]    = 1'b1;
            if (hit_ff) begin
               if (!ent_cont) begin
                  cnt_we              = 1'b1;
                  cnt_wdata           = {1'b0, dec_cnt};
                  work_in[hit_idx_ff] = (dec_cnt != '0);
               end
               cur_in = hit_idx_ff;
               run_in = 1'b1;
            end else begin
               run_in = 1'b0;
            end
         end
         acss_pkg::OP_QUERY: begin
            if (in_range_ff) begin
               flag_out           = done_ff[ch_idx_ff];
               done_in[ch_idx_ff] = 1'b0;
               smp_out            = smp_vld_ff[ch_idx_ff] ? smp_rd_ff : '0;
            end
         end
         default: begin
            // unused opcode: status only
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_accept) state_in = S_EXEC;
         S_EXEC: if (exec_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         run_ff       <= 1'b0;
         done_ff      <= '0;
         work_ff      <= '0;
         cnt_vld_ff   <= '0;
         smp_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            cur_ff     <= cur_in;
            run_ff     <= run_in;
            done_ff    <= done_in;
            work_ff    <= work_in;
            cnt_vld_ff <= cnt_vld_in;
            smp_vld_ff <= smp_vld_in;
         end
      end
   end

   // command payload, held through execute
   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff       <= req_op;
         ch_idx_ff   <= req_idx;
         in_range_ff <= req_in_range;
         cont_ff     <= req_tdata[ChW];
         smp_ff      <= req_tdata[ChW+SmpW:ChW+1];
         hit_ff      <= srch_found;
         hit_idx_ff  <= srch_idx;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_chan_ff <= ChW'(cur_in);
         rsp_conv_ff <= run_in;
         rsp_flag_ff <= flag_out;
         rsp_smp_ff  <= smp_out;
      end
   end

   // count/mark RAM: read at accept, write back in execute
   always_ff @(posedge clock) begin
      if (cnt_we && exec_fire) begin
         cnt_mem_ff[cnt_addr] <= cnt_wdata;
      end
      if (req_accept) begin
         cnt_rd_ff <= cnt_mem_ff[cnt_raddr];
      end
   end

   // sample RAM: written on conversion done, read for queries
   always_ff @(posedge clock) begin
      if (smp_we && exec_fire) begin
         smp_mem_ff[cur_ff] <= smp_ff;
      end
      if (req_accept) begin
         smp_rd_ff <= smp_mem_ff[req_idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_smp_ff, rsp_flag_ff, rsp_conv_ff, rsp_chan_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ACSS_ASSERT_IMP(a_flag_has_sample, clock, reset, 1'b1, (done_ff & ~smp_vld_ff) == '0, "done flag set on a channel without a stored sample")
   `ACSS_ASSERT_IMP(a_count_bound, clock, reset, cnt_we && exec_fire && !cnt_wdata[CountBits], cnt_wdata[CountBits-1:0] <= CountMax, "pending count written above its limit")
   `ACSS_ASSERT_IMP(a_cont_no_count, clock, reset, cnt_we && exec_fire && cnt_wdata[CountBits], cnt_wdata[CountBits-1:0] == '0, "continuous channel written with a pending count")
   `ACSS_ASSERT_NXT(a_rsp_after_exec, clock, reset, exec_fire, rsp_tvalid && (state_ff == S_IDLE), "write-back did not produce a response")

endmodule

// ===== rtl/acss_rr_search.sv =====
// Round-robin search for the next channel with work left.
// Standalone; instantiated by the scheduler top level.
module acss_rr_search #(
   parameter int Channels = 16,
   parameter int IdxW     = 4
) (
   input  logic [Channels-1:0] work,
   input  logic [IdxW-1:0]     cur,
   output logic                found,
   output logic [IdxW-1:0]     idx
);

   logic            hi_hit;
   logic [IdxW-1:0] hi_idx;
   logic [IdxW-1:0] lo_idx;

   // lowest set channel above cur wins, else lowest set overall (cur last)
   always_comb begin
      found  = 1'b0;
      hi_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int i = Channels - 1; i >= 0; i--) begin
         if (work[i]) begin
            found  = 1'b1;
            lo_idx = IdxW'(i);
            if (IdxW'(i) > cur) begin
               hi_hit = 1'b1;
               hi_idx = IdxW'(i);
            end
         end
      end
      idx = hi_hit ? hi_idx : lo_idx;
   end

endmodule

// ===== verif/adc_channel_scan_scheduler_top_tb.sv =====
// Self-checking testbench for the ADC channel scan scheduler top level.
// Depends on acss_pkg and adc_channel_scan_scheduler_top; predicts every response word.
module adc_channel_scan_scheduler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH    = acss_pkg::CHANNELS_DEF;
   localparam int CNT_W     = acss_pkg::COUNT_BITS_DEF;
   localparam int COUNT_MAX = (1 << CNT_W) - 2;   // single-count saturation

   // One response word, unpacked.
   typedef struct packed {
      logic [acss_pkg::CHAN_BITS-1:0]   chan;
      logic                             conv;
      logic                             flag;
      logic [acss_pkg::SAMPLE_BITS-1:0] smp;
   } scan_status_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   // channel[3:0], continuous[4], sample[16:5], zero
   logic [acss_pkg::WORD_BITS-1:0]   req_tdata;
   logic [acss_pkg::OPCODE_BITS-1:0] req_tuser;    // opcode[1:0]
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   // channel[3:0], converting[4], flag[5], sample[17:6]
   logic [acss_pkg::WORD_BITS-1:0]   rsp_tdata;

   adc_channel_scan_scheduler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Scheduler state as the testbench sees it
   // ------------------------------------------------------------------
   logic [acss_pkg::SAMPLE_BITS-1:0] sched_sample [NUM_CH];
   logic [CNT_W-1:0]                 sched_count  [NUM_CH];
   logic                             sched_cont   [NUM_CH];
   logic [NUM_CH-1:0]                sched_done;
   logic [acss_pkg::CHAN_BITS-1:0]   sched_cur;
   logic                             sched_run;

   scan_status_type status_q [$];   // response words still owed by the block
   int              errors;
   bit              gaps_on;        // random idling on both sides

   task automatic clear_schedule();
      for (int i = 0; i < NUM_CH; i++) begin
         sched_sample[i] = '0;
         sched_count[i]  = '0;
         sched_cont[i]   = 1'b0;
      end
      sched_done = '0;
      sched_cur  = '0;
      sched_run  = 1'b0;
   endtask

   // Applies one command word to the schedule and returns the status it yields.
   function automatic scan_status_type schedule_word(acss_pkg::opcode_type op,
                                                     logic [3:0] ch, logic cont,
                                                     logic [11:0] smp);
      scan_status_type st;
      logic [3:0]      nxt;
      logic            found;
      st    = '0;
      found = 1'b0;
      case (op)
         acss_pkg::OP_REQUEST: begin
            if (cont) begin
               sched_cont[ch]  = 1'b1;
               sched_count[ch] = '0;
            end else if (sched_cont[ch]) begin
               // continuous channel drops back to exactly one single conversion
               sched_cont[ch]  = 1'b0;
               sched_count[ch] = CNT_W'(1);
            end else if (sched_count[ch] < COUNT_MAX) begin
               sched_count[ch] = sched_count[ch] + 1'b1;
            end
            sched_cur = ch;
            sched_run = 1'b1;
         end
         acss_pkg::OP_DONE: begin
            sched_sample[sched_cur] = smp;
            sched_done[sched_cur]   = 1'b1;
            // rotate from the channel after the current one; current one last
            for (int k = 1; k <= NUM_CH; k++) begin
               nxt = sched_cur + 4'(k);
               if (!found && (sched_cont[nxt] || sched_count[nxt] != 0)) begin
                  found = 1'b1;
                  if (!sched_cont[nxt])
                     sched_count[nxt] = sched_count[nxt] - 1'b1;
                  sched_cur = nxt;
               end
            end
            sched_run = found;
         end
         acss_pkg::OP_QUERY: begin
            st.flag        = sched_done[ch];
            st.smp         = sched_sample[ch];
            sched_done[ch] = 1'b0;
         end
         default: ;   // unused opcode: status only
      endcase
      st.chan = sched_cur;
      st.conv = sched_run;
      return st;
   endfunction

   // ------------------------------------------------------------------
   // Command side. Inputs move at the falling edge (blocking, so a valid
   // that stays high across words is never lowered and raised by NBAs).
   // ------------------------------------------------------------------
   task automatic send_word(acss_pkg::opcode_type op, logic [3:0] ch, logic cont,
                            logic [11:0] smp);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {7'd0, smp, cont, ch};
      do @(posedge clock); while (!req_tready);
      status_q.push_back(schedule_word(op, ch, cont, smp));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_results();
      while (status_q.size() != 0) @(negedge clock);
   endtask

   // Issues conversion-done words until the converter stops on its own.
   task automatic run_scan_dry();
      while (sched_run)
         send_word(acss_pkg::OP_DONE, 4'($urandom), 1'($urandom), 12'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts on tready, checked at the rising edge.
   // ------------------------------------------------------------------
   initial begin : rsp_stall
      int hold;
      hold       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_tready = 1'b0;
         end else if (gaps_on && $urandom_range(0, 15) == 0) begin
            hold       = $urandom_range(1, 18) - 1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      scan_status_type want;
      scan_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[5], rsp_tdata[17:6]};
         if (status_q.size() == 0) begin
            $display("%0t: unexpected response word %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = status_q.pop_front();
            if (got.chan !== want.chan) begin
               $display("%0t: active_channel exp %0d got %0d", $time, want.chan, got.chan);
               errors++;
            end
            if (got.conv !== want.conv) begin
               $display("%0t: converting exp %0b got %0b", $time, want.conv, got.conv);
               errors++;
            end
            if (got.flag !== want.flag) begin
               $display("%0t: done_flag exp %0b got %0b", $time, want.flag, got.flag);
               errors++;
            end
            if (got.smp !== want.smp) begin
               $display("%0t: stored_sample exp %h got %h", $time, want.smp, got.smp);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked corner cases, all with a known outcome.
   task automatic test_directed_cases();
      send_word(acss_pkg::OP_QUERY, 4'd0, 1'b0, 12'h000);     // nothing converted yet
      send_word(acss_pkg::OP_NONE, 4'hF, 1'b1, 12'hFFF);      // unused opcode, status only
      send_word(acss_pkg::OP_DONE, 4'hF, 1'b1, 12'hFFF);      // done while stopped
      send_word(acss_pkg::OP_QUERY, 4'd0, 1'b0, 12'h000);     // flag set, sample all ones
      send_word(acss_pkg::OP_QUERY, 4'd0, 1'b1, 12'hFFF);     // flag cleared by the read
      send_word(acss_pkg::OP_REQUEST, 4'hF, 1'b0, 12'h000);   // highest channel, single
      send_word(acss_pkg::OP_REQUEST, 4'd0, 1'b1, 12'h000);   // lowest channel, continuous
      send_word(acss_pkg::OP_DONE, 4'd0, 1'b0, 12'h000);      // picks pending channel 15
      send_word(acss_pkg::OP_DONE, 4'd3, 1'b0, 12'hAAA);      // wraps to continuous 0
      send_word(acss_pkg::OP_DONE, 4'd0, 1'b0, 12'h555);      // only continuous 0 left
      send_word(acss_pkg::OP_REQUEST, 4'd0, 1'b0, 12'hFFF);   // continuous back to one single
      send_word(acss_pkg::OP_DONE, 4'd0, 1'b0, 12'h123);      // current channel checked last
      send_word(acss_pkg::OP_DONE, 4'd0, 1'b0, 12'h456);      // no work left: converter stops
      send_word(acss_pkg::OP_QUERY, 4'hF, 1'b0, 12'h000);
      send_word(acss_pkg::OP_QUERY, 4'd0, 1'b0, 12'h000);
      send_word(acss_pkg::OP_REQUEST, 4'd7, 1'b1, 12'h000);
      send_word(acss_pkg::OP_REQUEST, 4'd7, 1'b0, 12'h000);   // back to count 1
      send_word(acss_pkg::OP_REQUEST, 4'd7, 1'b0, 12'h000);   // count 2
      send_word(acss_pkg::OP_REQUEST, 4'd2, 1'b0, 12'h000);
      repeat (4) send_word(acss_pkg::OP_DONE, 4'd0, 1'b0, 12'($urandom));
      send_word(acss_pkg::OP_QUERY, 4'd7, 1'b0, 12'h000);
      send_word(acss_pkg::OP_QUERY, 4'd2, 1'b0, 12'h000);
   endtask

   // Pile single requests onto one channel past the limit, then drain it.
   task automatic test_count_saturation();
      for (int i = 0; i < NUM_CH; i++)
         if (sched_cont[i]) send_word(acss_pkg::OP_REQUEST, 4'(i), 1'b0, 12'h000);
      run_scan_dry();
      repeat (COUNT_MAX + 3)
         send_word(acss_pkg::OP_REQUEST, 4'd9, 1'b0, 12'($urandom));
      run_scan_dry();
      send_word(acss_pkg::OP_QUERY, 4'd9, 1'b0, 12'h000);
   endtask

   // Random command mix over channels 0..max_ch.
   task automatic test_random_scan(int words, int max_ch, int cont_pct);
      int         r;
      logic [3:0] ch;
      for (int i = 0; i < words; i++) begin
         r  = $urandom_range(0, 99);
         ch = 4'($urandom_range(0, max_ch));
         if (r < 30)
            send_word(acss_pkg::OP_REQUEST, ch, $urandom_range(0, 99) < cont_pct,
                      12'($urandom));
         else if (r < 70)
            send_word(acss_pkg::OP_DONE, 4'($urandom), 1'($urandom), 12'($urandom));
         else if (r < 95)
            send_word(acss_pkg::OP_QUERY, ch, 1'($urandom), 12'($urandom));
         else
            send_word(acss_pkg::OP_NONE, 4'($urandom), 1'($urandom), 12'($urandom));
      end
   endtask

   initial begin : main_seq
      errors     = 0;
      gaps_on    = 1'b1;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = acss_pkg::OP_NONE;
      req_tdata  = '0;
      clear_schedule();
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_count_saturation();
      test_random_scan(220, NUM_CH - 1, 25);
      // hold off until the block has answered everything
      wait_for_results();
      repeat (5) @(negedge clock);
      test_random_scan(220, 3, 10);
      gaps_on = 1'b0;             // final stretch at full rate
      test_random_scan(220, NUM_CH - 1, 20);

      wait_for_results();
      repeat (10) @(posedge clock);
      if (errors == 0)
         $display("PASS adc_channel_scan_scheduler_top");
      else
         $display("FAIL adc_channel_scan_scheduler_top");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin : watchdog
      #5_000_000;
      $display("FAIL adc_channel_scan_scheduler_top");
      $finish;
   end

endmodule
